### src/ugrt_pkg.sv
// Package for the uniform grid ray traversal block.
// Holds time format constants, the controller state enum and the command/status structs.
`default_nettype none
package ugrt_pkg;
  localparam int AXIS_CELLS_MAX = 16;
  localparam int TIME_BITS = 32;
  localparam int POS_W = $clog2(AXIS_CELLS_MAX);
  localparam int SIZE_W = POS_W + 1;
  localparam int REG_W = 5;
  localparam logic signed [TIME_BITS-1:0] INFINITY = {1'b0, {(TIME_BITS-1){1'b1}}};
  localparam logic signed [TIME_BITS-1:0] TIME_MIN = {1'b1, {(TIME_BITS-1){1'b0}}};
  localparam logic [1:0] DIR_ZERO = 2'd0;
  localparam logic [1:0] DIR_POS = 2'd1;
  localparam logic [1:0] DIR_NEG = 2'd2;
  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;
  // quotient bits: difference is TIME_BITS+1 wide
  localparam int DIFF_W = TIME_BITS + 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_FIRST, ST_WALK, ST_HOLD
  } ctrl_state_t;

  typedef struct packed {
    logic load;       // capture the ray
    logic div_start;  // start divider on axis div_axis
    logic [1:0] div_axis;
    logic first;      // form first crossing for axis div_axis
    logic step;       // emit a cell and advance
  } ugrt_cmd_t;

  typedef struct packed {
    logic div_done;
    logic walk_done;
  } ugrt_status_t;

  function automatic logic signed [TIME_BITS-1:0] sat_time(input logic signed [2*TIME_BITS+1:0] v);
    if (v > $signed({{(TIME_BITS+2){1'b0}}, INFINITY})) return INFINITY;
    if (v < $signed({{(TIME_BITS+2){1'b1}}, TIME_MIN})) return TIME_MIN;
    return v[TIME_BITS-1:0];
  endfunction
endpackage
`default_nettype wire

### src/ugrt_if.sv
// Valid/ready channel interfaces for ray items and cell results.
// Imports ugrt_pkg; the port widths are given as literals.
`default_nettype none
interface ugrt_ray_if import ugrt_pkg::*; ();
  logic valid;
  logic ready;
  logic [3:0] start_x, start_y, start_z;
  logic signed [31:0] enter_time_x, enter_time_y, enter_time_z;
  logic signed [31:0] leave_time_x, leave_time_y, leave_time_z;
  logic [5:0] dir_code;
  modport source (output valid, start_x, start_y, start_z, enter_time_x, enter_time_y,
    enter_time_z, leave_time_x, leave_time_y, leave_time_z, dir_code, input ready);
  modport sink (input valid, start_x, start_y, start_z, enter_time_x, enter_time_y,
    enter_time_z, leave_time_x, leave_time_y, leave_time_z, dir_code, output ready);
endinterface

interface ugrt_cell_if import ugrt_pkg::*; ();
  logic valid;
  logic ready;
  logic [11:0] cell_index;
  logic signed [31:0] exit_time;
  logic last;
  modport source (output valid, cell_index, exit_time, last, input ready);
  modport sink (input valid, cell_index, exit_time, last, output ready);
endinterface
`default_nettype wire

### src/ugrt_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, truncates toward zero.
// Depends on ugrt_pkg.
`default_nettype none
module ugrt_div import ugrt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic signed [DIFF_W-1:0] dividend,
  input  wire logic [SIZE_W-1:0] divisor,
  output logic done,
  output logic signed [TIME_BITS-1:0] quotient
);
  localparam int CNT_W = $clog2(DIFF_W + 1);
  logic [DIFF_W-1:0] quo;
  logic [SIZE_W:0] rem;
  logic [SIZE_W-1:0] dvs;
  logic neg;
  logic busy;
  logic [CNT_W-1:0] cnt;
  logic [SIZE_W:0] trial;
  logic signed [DIFF_W:0] q_signed;

  assign trial = {rem[SIZE_W-1:0], quo[DIFF_W-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIFF_W);
        quo  <= dividend[DIFF_W-1] ? DIFF_W'(-dividend) : dividend;
        neg  <= dividend[DIFF_W-1];
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        if (!trial[SIZE_W]) begin
          rem <= trial;
          quo <= {quo[DIFF_W-2:0], 1'b1};
        end else begin
          rem <= {rem[SIZE_W-1:0], quo[DIFF_W-1]};
          quo <= {quo[DIFF_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // magnitude fits DIFF_W bits unsigned; saturate after sign
  assign q_signed = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign quotient = sat_time((2*TIME_BITS+2)'(q_signed));
endmodule
`default_nettype wire

### src/ugrt_datapath.sv
// Datapath: ray registers, shared divider, first crossing, axis choice and cell step.
// Depends on ugrt_pkg and ugrt_div.
`default_nettype none
module ugrt_datapath import ugrt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire ugrt_cmd_t cmd,
  output ugrt_status_t status,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [REG_W-1:0] cfg_data,
  input  wire logic [3:0] in_start [3],
  input  wire logic signed [31:0] in_enter [3],
  input  wire logic signed [31:0] in_leave [3],
  input  wire logic [5:0] in_dir,
  output logic [11:0] cell_index,
  output logic signed [31:0] exit_time,
  output logic last
);
  logic [REG_W-1:0] grid_reg [3];
  logic [SIZE_W-1:0] size [3];
  logic [POS_W-1:0] pos [3];
  logic signed [TIME_BITS-1:0] enter [3];
  logic signed [TIME_BITS-1:0] leave [3];
  logic signed [TIME_BITS-1:0] next_cross_time [3];
  logic signed [TIME_BITS-1:0] cross_step_time [3];
  logic [1:0] axis_direction [3];
  logic [11:0] row_base, layer_base;

  logic div_done;
  logic signed [TIME_BITS-1:0] quotient;
  logic signed [DIFF_W-1:0] diff;
  logic [1:0] ax;
  logic [1:0] da;
  logic signed [SIZE_W+TIME_BITS:0] first_prod;
  logic signed [2*TIME_BITS+1:0] first_sum;
  logic [SIZE_W-1:0] mult;
  logic [1:0] sel;
  logic all_zero, done_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_reg[0] <= REG_W'(16);
      grid_reg[1] <= REG_W'(16);
      grid_reg[2] <= REG_W'(16);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIZE_X: grid_reg[0] <= cfg_data;
        REG_SIZE_Y: grid_reg[1] <= cfg_data;
        REG_SIZE_Z: grid_reg[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (grid_reg[i] == '0) size[i] = SIZE_W'(1);
      else if (grid_reg[i] > REG_W'(AXIS_CELLS_MAX)) size[i] = SIZE_W'(AXIS_CELLS_MAX);
      else size[i] = SIZE_W'(grid_reg[i]);
    end
  end

  assign da = cmd.div_axis;
  assign diff = DIFF_W'(leave[da]) - DIFF_W'(enter[da]);
  assign mult = (axis_direction[da] == DIR_POS) ? SIZE_W'(pos[da]) + 1'b1
                                               : size[da] - SIZE_W'(pos[da]);
  assign first_prod = $signed({1'b0, mult}) * cross_step_time[da];
  assign first_sum = (2*TIME_BITS+2)'(enter[da]) + (2*TIME_BITS+2)'(first_prod);

  ugrt_div u_div (.clk, .rst, .start(cmd.div_start), .dividend(diff),
    .divisor(size[da]), .done(div_done), .quotient);

  function automatic logic earlier(input logic [1:0] a, input logic [1:0] b,
      input logic [1:0] dir [3], input logic signed [TIME_BITS-1:0] t [3]);
    if (dir[a] == DIR_ZERO) return 1'b0;
    if (dir[b] == DIR_ZERO) return 1'b1;
    return t[a] < t[b];
  endfunction

  always_comb begin
    if (earlier(2'd0, 2'd1, axis_direction, next_cross_time)
        && earlier(2'd0, 2'd2, axis_direction, next_cross_time)) sel = 2'd0;
    else if (earlier(2'd1, 2'd2, axis_direction, next_cross_time)) sel = 2'd1;
    else sel = 2'd2;
  end
  assign ax = sel;
  assign all_zero = (axis_direction[0] == DIR_ZERO) && (axis_direction[1] == DIR_ZERO)
                 && (axis_direction[2] == DIR_ZERO);
  assign done_now = all_zero ||
    ((axis_direction[ax] == DIR_POS) ? (SIZE_W'(pos[ax]) + 1'b1 >= size[ax])
                                     : (pos[ax] == '0));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 3; i++) begin
        pos[i] <= (SIZE_W'(in_start[i]) > size[i] - 1'b1) ? POS_W'(size[i] - 1'b1)
                                                         : POS_W'(in_start[i]);
        enter[i] <= in_enter[i];
        leave[i] <= in_leave[i];
        axis_direction[i] <= (in_dir[2*i +: 2] == DIR_POS || in_dir[2*i +: 2] == DIR_NEG)
                             ? in_dir[2*i +: 2] : DIR_ZERO;
      end
      row_base   <= 12'(size[0]);
      layer_base <= 12'(size[0]) * 12'(size[1]);
    end
    if (div_done) cross_step_time[da] <= quotient;
    if (cmd.first) begin
      next_cross_time[da] <= (axis_direction[da] == DIR_ZERO) ? INFINITY : sat_time(first_sum);
    end
    if (cmd.step) begin
      cell_index <= 12'(pos[0]) + 12'(row_base * 12'(pos[1])) + 12'(layer_base * 12'(pos[2]));
      last <= done_now;
      if (all_zero) begin
        exit_time <= INFINITY;
      end else begin
        exit_time <= next_cross_time[ax];
        next_cross_time[ax] <= sat_time((2*TIME_BITS+2)'(next_cross_time[ax])
                                      + (2*TIME_BITS+2)'(cross_step_time[ax]));
        if (!done_now) begin
          if (axis_direction[ax] == DIR_POS) pos[ax] <= pos[ax] + 1'b1;
          else pos[ax] <= pos[ax] - 1'b1;
        end
      end
    end
  end

  assign status.div_done = div_done;
  assign status.walk_done = done_now;
endmodule
`default_nettype wire

### src/ugrt_ctrl.sv
// Controller FSM: sequences the three divisions, first crossings and the cell walk.
// Depends on ugrt_pkg.
`default_nettype none
module ugrt_ctrl import ugrt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  input  wire ugrt_status_t status,
  output ugrt_cmd_t cmd
);
  ctrl_state_t state, state_next;
  logic [1:0] axis, axis_next;
  logic busy_div, busy_div_next;
  logic ov, ov_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      axis <= '0;
      busy_div <= 1'b0;
      ov <= 1'b0;
    end else begin
      state <= state_next;
      axis <= axis_next;
      busy_div <= busy_div_next;
      ov <= ov_next;
    end
  end

  // output register may step when empty or being taken
  logic slot_free;
  assign slot_free = !ov || out_ready;

  always_comb begin
    state_next = state;
    axis_next = axis;
    busy_div_next = busy_div;
    ov_next = ov && !out_ready;
    case (state)
      ST_IDLE: if (in_valid) begin
        state_next = ST_DIV;
        axis_next = '0;
        busy_div_next = 1'b0;
      end
      ST_DIV: begin
        if (!busy_div) busy_div_next = 1'b1;
        else if (status.div_done) begin
          busy_div_next = 1'b0;
          state_next = ST_FIRST;
        end
      end
      ST_FIRST: begin
        if (axis == 2'd2) begin
          state_next = ST_WALK;
          axis_next = '0;
        end else begin
          axis_next = axis + 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_WALK: if (slot_free) begin
        ov_next = 1'b1;
        if (status.walk_done) state_next = ST_HOLD;
      end
      ST_HOLD: if (!ov_next) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.div_axis = axis;
    in_ready = (state == ST_IDLE);
    case (state)
      ST_IDLE: cmd.load = in_valid;
      ST_DIV: cmd.div_start = !busy_div;
      ST_FIRST: cmd.first = 1'b1;
      ST_WALK: cmd.step = slot_free;
      default: ;
    endcase
  end

  assign out_valid = ov;
endmodule
`default_nettype wire

### src/uniform_grid_ray_traversal.sv
// Top level of the uniform grid ray traversal block.
// Depends on ugrt_pkg, ugrt_if, ugrt_ctrl and ugrt_datapath.
`default_nettype none
// Walks one ray through a grid of up to 16x16x16 cells and emits each visited cell with
// the time the ray leaves it; the final cell carries last. Rays are handled one at a time.
// After a ray is accepted, setup runs three divisions on one shared bit-serial divider,
// each with a start and a first-crossing step; then one cell per cycle while the output
// is taken (up to 46 cells), then a drain state until the last cell is taken. The walk
// waits while the output stalls.
// Write grid sizes only between rays.
module uniform_grid_ray_traversal import ugrt_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_we,
  input wire logic [1:0] cfg_index,
  input wire logic [REG_W-1:0] cfg_data,
  ugrt_ray_if.sink ray,
  ugrt_cell_if.source voxel
);
  ugrt_cmd_t cmd;
  ugrt_status_t status;
  logic [3:0] st [3];
  logic signed [31:0] en [3];
  logic signed [31:0] lv [3];

  assign st = '{ray.start_x, ray.start_y, ray.start_z};
  assign en = '{ray.enter_time_x, ray.enter_time_y, ray.enter_time_z};
  assign lv = '{ray.leave_time_x, ray.leave_time_y, ray.leave_time_z};

  ugrt_ctrl u_ctrl (.clk, .rst, .in_valid(ray.valid), .in_ready(ray.ready),
    .out_valid(voxel.valid), .out_ready(voxel.ready), .status, .cmd);

  ugrt_datapath u_dp (.clk, .rst, .cmd, .status, .cfg_we, .cfg_index, .cfg_data,
    .in_start(st), .in_enter(en), .in_leave(lv), .in_dir(ray.dir_code),
    .cell_index(voxel.cell_index), .exit_time(voxel.exit_time), .last(voxel.last));

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    voxel.valid |-> !ray.ready) else $error("ray taken while results pending");
  a_step_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (!voxel.valid || voxel.ready)) else $error("result overwritten");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.div_start, cmd.first, cmd.step})) else $error("command clash");
`endif
endmodule
`default_nettype wire

### tb/tb_channels.sv
// Testbench view of the ray and cell channels.
// The channel interfaces themselves come from src/ugrt_if.sv, which depends on ugrt_pkg.
// This file holds the item structs shared by driver, predictor and monitor.
package tb_ray_types;
  timeunit 1ns;
  timeprecision 1ps;
  typedef struct {
    logic [3:0] sx, sy, sz;
    logic signed [31:0] ent[3];
    logic signed [31:0] lev[3];
    logic [5:0] dir;
  } ray_item_t;
  typedef struct {
    logic [11:0] idx;
    logic signed [31:0] t;
    logic last;
  } cell_item_t;
endpackage

### tb/testbench.sv
// Self-checking testbench for uniform_grid_ray_traversal.
// Depends on ugrt_pkg, ugrt_if (src) and tb_ray_types; predicts each visited cell
// of every ray and compares results in order, under random idling on both channels except in the last phases.
module testbench;
  import ugrt_pkg::*;
  import tb_ray_types::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_SIZE_X;
  logic [REG_W-1:0] cfg_data = '0;

  ugrt_ray_if ray ();
  ugrt_cell_if voxel ();

  uniform_grid_ray_traversal i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .ray(ray), .voxel(voxel)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ray_item_t pending_rays[$];
  cell_item_t expected_cells[$];
  ray_item_t cur_ray;
  logic [4:0] size_reg[3] = '{5'd16, 5'd16, 5'd16};
  int send_idle_pct = 16;
  int recv_idle_pct = 68;
  int error_count = 0;
  int rays_sent = 0;
  int cells_seen = 0;
  int last_seen = 0;
  longint cycle_count = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic add_pending(input ray_item_t r);
    pending_rays.insert(pending_rays.size(), r);
  endtask

  task automatic add_expected(input cell_item_t c);
    expected_cells.insert(expected_cells.size(), c);
  endtask

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    if (v > 72'sd2147483647) return 32'sh7fffffff;
    if (v < -72'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic int clamp_size(input logic [4:0] r);
    if (r == 0) return 1;
    if (r > AXIS_CELLS_MAX) return AXIS_CELLS_MAX;
    return int'(r);
  endfunction

  function automatic logic sooner(input int a, input int b, input logic [1:0] d[3],
                                  input logic signed [31:0] ct[3]);
    if (d[a] == DIR_ZERO) return 1'b0;
    if (d[b] == DIR_ZERO) return 1'b1;
    return ct[a] < ct[b];
  endfunction

  // Walk one ray through the grid and queue every visited cell.
  task automatic predict_ray_walk(input ray_item_t r);
    int sz[3], pos[3], ax, n;
    logic [1:0] dirs[3];
    logic signed [31:0] step_t[3], cross_t[3], t;
    logic signed [71:0] diff;
    logic [3:0] st[3];
    logic done;
    cell_item_t c;
    st = '{r.sx, r.sy, r.sz};
    for (int a = 0; a < 3; a++) begin
      sz[a] = clamp_size(size_reg[a]);
      pos[a] = (int'(st[a]) > sz[a] - 1) ? sz[a] - 1 : int'(st[a]);
      diff = 72'(r.lev[a]) - 72'(r.ent[a]);
      step_t[a] = sat32(diff / sz[a]);
      dirs[a] = r.dir[2*a +: 2];
      if (dirs[a] == DIR_POS)
        cross_t[a] = sat32(72'(r.ent[a]) + 72'(pos[a] + 1) * 72'(step_t[a]));
      else if (dirs[a] == DIR_NEG)
        cross_t[a] = sat32(72'(r.ent[a]) + 72'(sz[a] - pos[a]) * 72'(step_t[a]));
      else begin
        dirs[a] = DIR_ZERO;
        cross_t[a] = INFINITY;
      end
    end
    n = 0;
    done = 1'b0;
    while (!done && n < 3 * (AXIS_CELLS_MAX - 1) + 1) begin
      c.idx = 12'(pos[0] + sz[0] * pos[1] + sz[0] * sz[1] * pos[2]);
      if (dirs[0] == DIR_ZERO && dirs[1] == DIR_ZERO && dirs[2] == DIR_ZERO) begin
        t = INFINITY;
        done = 1'b1;
      end else begin
        if (sooner(0, 1, dirs, cross_t) && sooner(0, 2, dirs, cross_t)) ax = 0;
        else if (sooner(1, 2, dirs, cross_t)) ax = 1;
        else ax = 2;
        t = cross_t[ax];
        cross_t[ax] = sat32(72'(t) + 72'(step_t[ax]));
        if (dirs[ax] == DIR_POS) begin
          if (pos[ax] + 1 >= sz[ax]) done = 1'b1;
          else pos[ax]++;
        end else begin
          if (pos[ax] == 0) done = 1'b1;
          else pos[ax]--;
        end
      end
      n++;
      c.t = t;
      c.last = done || (n == 3 * (AXIS_CELLS_MAX - 1) + 1);
      add_expected(c);
    end
  endtask

  // Driver: present queued rays, hold each until taken.
  always @(posedge clk) begin
    if (rst) begin
      ray.valid <= 1'b0;
    end else begin
      if (ray.valid && ray.ready) begin
        predict_ray_walk(cur_ray);
        rays_sent++;
      end
      if (!(ray.valid && !ray.ready)) begin
        if (pending_rays.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_ray = pending_rays.pop_front();
          ray.valid <= 1'b1;
          ray.start_x <= cur_ray.sx;
          ray.start_y <= cur_ray.sy;
          ray.start_z <= cur_ray.sz;
          ray.enter_time_x <= cur_ray.ent[0];
          ray.enter_time_y <= cur_ray.ent[1];
          ray.enter_time_z <= cur_ray.ent[2];
          ray.leave_time_x <= cur_ray.lev[0];
          ray.leave_time_y <= cur_ray.lev[1];
          ray.leave_time_z <= cur_ray.lev[2];
          ray.dir_code <= cur_ray.dir;
        end else begin
          ray.valid <= 1'b0;
        end
      end
    end
  end

  initial begin
    ray.valid = 1'b0;
    ray.start_x = '0; ray.start_y = '0; ray.start_z = '0;
    ray.enter_time_x = '0; ray.enter_time_y = '0; ray.enter_time_z = '0;
    ray.leave_time_x = '0; ray.leave_time_y = '0; ray.leave_time_z = '0;
    ray.dir_code = '0;
    voxel.ready = 1'b0;
  end

  // Monitor: take cells with random stalls when enabled, compare against the oldest expectation.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      voxel.ready <= 1'b0;
    end else begin
      if (voxel.valid && voxel.ready) begin
        cells_seen++;
        if (voxel.last) last_seen++;
        if (expected_cells.size() == 0) begin
          report_mismatch($sformatf("unexpected cell idx=%0d", voxel.cell_index));
        end else begin
          cell_item_t e;
          e = expected_cells.pop_front();
          if (voxel.cell_index !== e.idx)
            report_mismatch($sformatf("cell_index %0d, want %0d", voxel.cell_index, e.idx));
          if (voxel.exit_time !== e.t)
            report_mismatch($sformatf("exit_time %h, want %h", voxel.exit_time, e.t));
          if (voxel.last !== e.last)
            report_mismatch($sformatf("last %b, want %b", voxel.last, e.last));
        end
      end
      voxel.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic signed [31:0] rand_time(input int mode);
    case (mode)
      0: return $signed($urandom());
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return $signed(32'($urandom_range(20 << 16)) - (2 << 16));
    endcase
  endfunction

  function automatic ray_item_t make_ray(input logic well_formed);
    ray_item_t r;
    r.sx = 4'($urandom()); r.sy = 4'($urandom()); r.sz = 4'($urandom());
    r.dir = 6'($urandom());
    for (int a = 0; a < 3; a++) begin
      if (well_formed) begin
        r.ent[a] = $signed(32'($urandom_range(4 << 16)));
        r.lev[a] = r.ent[a] + $signed(32'($urandom_range(40 << 16, 1)));
      end else begin
        r.ent[a] = rand_time($urandom_range(3));
        r.lev[a] = rand_time($urandom_range(3));
      end
    end
    if (well_formed && $urandom_range(1)) r.dir = {2'($urandom_range(2, 1)),
        2'($urandom_range(2, 1)), 2'($urandom_range(2, 1))};
    return r;
  endfunction

  task automatic write_size(input logic [1:0] idx, input logic [4:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    size_reg[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain_and_settle();
    while (pending_rays.size() > 0 || ray.valid || expected_cells.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic run_phase(input int count, input logic [4:0] sx, input logic [4:0] sy,
                           input logic [4:0] sz);
    write_size(REG_SIZE_X, sx);
    write_size(REG_SIZE_Y, sy);
    write_size(REG_SIZE_Z, sz);
    for (int i = 0; i < count; i++) add_pending(make_ray($urandom_range(9) < 8));
    drain_and_settle();
  endtask

  initial begin
    ray_item_t r;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // Directed rays at reset sizes: extremes, every direction code, saturation.
    for (int d = 0; d < 4; d++) begin
      r = make_ray(1'b1);
      r.dir = {2'(d), 2'(d), 2'(d)};
      r.sx = (d == 2) ? 4'd15 : 4'd0; r.sy = r.sx; r.sz = r.sx;
      add_pending(r);
    end
    r = make_ray(1'b0);
    r.ent = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
    r.lev = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
    r.dir = 6'b100101;
    add_pending(r);
    r.ent = r.lev; r.lev = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
    r.dir = 6'b011010;
    add_pending(r);
    r = make_ray(1'b1);
    r.lev = r.ent; r.dir = 6'b010101;
    add_pending(r);
    for (int i = 0; i < 8; i++) add_pending(make_ray(1'b0));
    drain_and_settle();
    // Size extremes including zero and out-of-range writes, start clamping.
    run_phase(6, 5'd0, 5'd31, 5'd1);
    run_phase(60, 5'd1, 5'd1, 5'd1);
    run_phase(70, 5'd16, 5'd16, 5'd16);
    send_idle_pct = 68; recv_idle_pct = 16;
    run_phase(70, 5'd5, 5'd17, 5'd3);
    run_phase(60, 5'd2, 5'd9, 5'd16);
    send_idle_pct = 0; recv_idle_pct = 0;
    run_phase(60, 5'd16, 5'd4, 5'd7);
    run_phase(40, 5'd16, 5'd16, 5'd16);
    $display("covered %0d rays, %0d cells, %0d ray ends", rays_sent, cells_seen, last_seen);
    if (error_count == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    if (cycle_count > 3000000) begin
      $display("timeout with %0d cells outstanding", expected_cells.size());
      $display("testbench: done, errors");
      $finish;
    end
  end
endmodule
